// ===== rtl/omc_pkg.sv =====
// ----------------------------------------------------------------------------
// omc_pkg
// Shared types, codes and the per-modifier step function of the oneshot
// modifier controller.
// ----------------------------------------------------------------------------
package omc_pkg;

  localparam int NUM_MODS  = 4;
  localparam int NUM_SLOTS = 6;
  localparam int KEY_W     = 16;

  // action codes
  localparam logic ACT_PRESS   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // output key codes
  localparam logic [2:0] KEY_SHIFT = 3'd0;
  localparam logic [2:0] KEY_CTRL  = 3'd1;
  localparam logic [2:0] KEY_ALT   = 3'd2;
  localparam logic [2:0] KEY_CMD   = 3'd3;
  localparam logic [2:0] KEY_SPACE = 3'd4;

  // input kinds
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // modifier phases
  localparam logic [2:0] PH_UP_UNQ    = 3'd0;
  localparam logic [2:0] PH_UP_QUE    = 3'd1;
  localparam logic [2:0] PH_UP_USED   = 3'd2;
  localparam logic [2:0] PH_DN_UNUSED = 3'd3;
  localparam logic [2:0] PH_DN_USED   = 3'd4;

  // register indexes
  localparam logic [2:0] REG_SHIFT_TRIG = 3'd0;
  localparam logic [2:0] REG_CTRL_TRIG  = 3'd1;
  localparam logic [2:0] REG_ALT_TRIG   = 3'd2;
  localparam logic [2:0] REG_CMD_TRIG   = 3'd3;
  localparam logic [2:0] REG_SWAP_TRIG  = 3'd4;
  localparam logic [2:0] REG_CANCEL_A   = 3'd5;
  localparam logic [2:0] REG_CANCEL_B   = 3'd6;
  localparam logic [2:0] REG_TIMEOUT    = 3'd7;

  // register file contents
  typedef struct packed {
    logic [NUM_MODS-1:0][KEY_W-1:0] mod_trig;
    logic [KEY_W-1:0]               swap_trig;
    logic [KEY_W-1:0]               cancel_a;
    logic [KEY_W-1:0]               cancel_b;
    logic [KEY_W-1:0]               timeout;
  } cfg_t;

  // one run of actions: slot 0 ctrl (swapper), slot 1 space,
  // slots 2 to 5 shift, ctrl, alt, cmd
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [NUM_SLOTS-1:0] act;
  } run_t;

  // outcome of one modifier unit
  typedef struct packed {
    logic       emit;
    logic       act;
    logic [2:0] ph_next;
    logic       arm_touch;
    logic       arm_val;
  } mod_res_t;

  function automatic mod_res_t mod_step(input logic [2:0] ph, input logic match,
                                        input logic down, input logic cancel,
                                        input logic oneshot);
    mod_res_t r;
    r.emit      = 1'b0;
    r.act       = ACT_RELEASE;
    r.ph_next   = ph;
    r.arm_touch = 1'b0;
    r.arm_val   = 1'b0;
    if (match) begin
      if (down) begin
        r.emit      = (ph == PH_UP_UNQ);
        r.act       = ACT_PRESS;
        r.ph_next   = PH_DN_UNUSED;
        r.arm_touch = 1'b1;
        r.arm_val   = 1'b0;
      end else if (ph == PH_DN_UNUSED) begin
        r.ph_next   = PH_UP_QUE;
        r.arm_touch = 1'b1;
        r.arm_val   = 1'b1;
      end else if (ph == PH_DN_USED) begin
        r.ph_next = PH_UP_UNQ;
        r.emit    = 1'b1;
      end
    end else if (down) begin
      if (cancel && ph != PH_UP_UNQ) begin
        r.ph_next = PH_UP_UNQ;
        r.emit    = 1'b1;
      end
      if (!oneshot) begin
        if (ph == PH_DN_UNUSED) begin
          r.ph_next = PH_DN_USED;
        end else if (ph == PH_UP_QUE) begin
          r.ph_next = PH_UP_USED;
        end else if (ph == PH_UP_USED) begin
          r.ph_next = PH_UP_UNQ;
          r.emit    = 1'b1;
        end
      end
    end else if (!oneshot) begin
      if (ph == PH_DN_UNUSED) begin
        r.ph_next = PH_DN_USED;
      end else if (ph == PH_UP_QUE || ph == PH_UP_USED) begin
        r.ph_next = PH_UP_UNQ;
        r.emit    = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/omc_cfg.sv =====
// ----------------------------------------------------------------------------
// omc_cfg
// Configuration register file: trigger keycodes, cancel keys and timeout.
// ----------------------------------------------------------------------------
module omc_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output omc_pkg::cfg_t       cfg
);
  import omc_pkg::*;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mod_trig[0] <= 16'd1;
      cfg.mod_trig[1] <= 16'd2;
      cfg.mod_trig[2] <= 16'd3;
      cfg.mod_trig[3] <= 16'd4;
      cfg.swap_trig   <= 16'd5;
      cfg.cancel_a    <= 16'd6;
      cfg.cancel_b    <= 16'd7;
      cfg.timeout     <= 16'd5000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SHIFT_TRIG: cfg.mod_trig[0] <= cfg_data;
        REG_CTRL_TRIG:  cfg.mod_trig[1] <= cfg_data;
        REG_ALT_TRIG:   cfg.mod_trig[2] <= cfg_data;
        REG_CMD_TRIG:   cfg.mod_trig[3] <= cfg_data;
        REG_SWAP_TRIG:  cfg.swap_trig   <= cfg_data;
        REG_CANCEL_A:   cfg.cancel_a    <= cfg_data;
        REG_CANCEL_B:   cfg.cancel_b    <= cfg_data;
        REG_TIMEOUT:    cfg.timeout     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/omc_core.sv =====
// ----------------------------------------------------------------------------
// omc_core
// Input register, modifier/swapper state and the single-pass step logic that
// turns one event into a run of up to six actions.
// ----------------------------------------------------------------------------
module omc_core (
  input  logic                clk,
  input  logic                rst,
  input  omc_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [15:0]         in_key,
  input  logic                in_down,
  output logic                run_push,
  input  logic                run_space,
  output omc_pkg::run_t       run
);
  import omc_pkg::*;

  logic                         held;
  logic                         op;
  logic [KEY_W-1:0]             key;
  logic                         down;
  logic                         advance;

  logic [NUM_MODS-1:0][2:0]     phase;
  logic [NUM_MODS-1:0][2:0]     phase_next;
  logic                         swap_active;
  logic                         swap_active_next;
  logic                         armed;
  logic                         armed_next;
  logic [KEY_W-1:0]             elapsed;
  logic [KEY_W-1:0]             elapsed_next;
  logic [KEY_W-1:0]             elapsed_inc;
  logic                         fire;
  logic                         cancel;
  logic                         oneshot;
  logic                         swap_match;
  logic                         touched;
  mod_res_t [NUM_MODS-1:0]      res;

  assign advance  = held && run_space;
  assign in_ready = !held || run_space;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op   <= in_op;
      key  <= in_key;
      down <= in_down;
    end
  end

  // key classification
  assign cancel     = (key == cfg.cancel_a) || (key == cfg.cancel_b);
  assign oneshot    = cancel || (key == cfg.mod_trig[0]) || (key == cfg.mod_trig[1])
                      || (key == cfg.mod_trig[2]) || (key == cfg.mod_trig[3]);
  assign swap_match = (key == cfg.swap_trig);

  // tick counter saturates at its top value
  assign elapsed_inc = (elapsed == {KEY_W{1'b1}}) ? elapsed : elapsed + 1'b1;
  assign fire        = armed && (elapsed_inc > cfg.timeout);

  // per-modifier units, independent of each other
  always_comb begin
    for (int m = 0; m < NUM_MODS; m++) begin
      res[m] = mod_step(phase[m], key == cfg.mod_trig[m], down, cancel, oneshot);
    end
  end

  // next state and action run
  always_comb begin
    phase_next       = phase;
    swap_active_next = swap_active;
    armed_next       = armed;
    elapsed_next     = elapsed;
    touched          = 1'b0;
    run.mask         = '0;
    run.act          = '0;
    if (op == OP_TICK) begin
      elapsed_next = elapsed_inc;
      if (fire) begin
        run.mask[NUM_SLOTS-1:2] = '1;
        run.act[NUM_SLOTS-1:2]  = '1;
        for (int m = 0; m < NUM_MODS; m++) begin
          phase_next[m] = PH_UP_UNQ;
        end
        armed_next   = 1'b0;
        elapsed_next = '0;
      end
    end else begin
      // swapper
      if (swap_match) begin
        run.mask[1] = 1'b1;
        run.act[1]  = down ? ACT_PRESS : ACT_RELEASE;
        if (down && !swap_active) begin
          run.mask[0]      = 1'b1;
          run.act[0]       = ACT_PRESS;
          swap_active_next = 1'b1;
        end
      end else if (swap_active) begin
        run.mask[0]      = 1'b1;
        run.act[0]       = ACT_RELEASE;
        swap_active_next = 1'b0;
      end
      // modifiers, later units win on the shared timeout
      for (int m = 0; m < NUM_MODS; m++) begin
        run.mask[m+2] = res[m].emit;
        run.act[m+2]  = res[m].act;
        phase_next[m] = res[m].ph_next;
        if (res[m].arm_touch) begin
          armed_next = res[m].arm_val;
          touched    = 1'b1;
        end
      end
      if (touched) begin
        elapsed_next = '0;
      end
    end
  end

  assign run_push = advance && (run.mask != '0);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int m = 0; m < NUM_MODS; m++) begin
        phase[m] <= PH_UP_UNQ;
      end
      swap_active <= 1'b0;
      armed       <= 1'b0;
      elapsed     <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      swap_active <= swap_active_next;
      armed       <= armed_next;
      elapsed     <= elapsed_next;
    end
  end

endmodule

// ===== rtl/omc_out.sv =====
// ----------------------------------------------------------------------------
// omc_out
// Two-run result queue and serializer: sends the actions of the head run one
// word per cycle while out_ready is high, in slot order; marks the final one.
// ----------------------------------------------------------------------------
module omc_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                run_push,
  output logic                run_space,
  input  omc_pkg::run_t       run,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_act,
  output logic [2:0]          out_key,
  output logic                out_last
);
  import omc_pkg::*;

  run_t                   q [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             count;
  run_t                   head;
  logic [NUM_SLOTS-1:0]   pick;
  logic [2:0]             slot;
  logic                   pop;

  assign head      = q[rd_ptr];
  assign out_valid = (count != 2'd0);
  assign run_space = (count != 2'd2);
  assign pop       = out_valid && out_ready;

  // lowest pending slot of the head run
  always_comb begin
    pick = '0;
    slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (head.mask[s]) begin
        pick    = '0;
        pick[s] = 1'b1;
        slot    = 3'(s);
      end
    end
  end

  // slot to key mapping
  always_comb begin
    case (slot)
      3'd0:    out_key = KEY_CTRL;
      3'd1:    out_key = KEY_SPACE;
      default: out_key = slot - 3'd2;
    endcase
  end

  assign out_act  = head.act[slot];
  assign out_last = ((head.mask & ~pick) == '0);

  // queue storage
  always_ff @(posedge clk) begin
    if (run_push) begin
      q[wr_ptr] <= run;
    end
    if (pop && !out_last) begin
      q[rd_ptr].mask <= head.mask & ~pick;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (run_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && out_last) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, run_push} - {1'b0, pop && out_last};
    end
  end

endmodule

// ===== rtl/oneshot_modifier_controller.sv =====
// ----------------------------------------------------------------------------
// oneshot_modifier_controller
// Oneshot shift/ctrl/alt/cmd modifiers with a ctrl+space swapper and a
// shared timeout on queued releases.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one word per event: a key event (keycode and
//   down/up) or a time tick, selected by s_tuser. Each word produces a run
//   of zero to six action words on the master channel (press or release of
//   shift, ctrl, alt, cmd or space); m_tlast marks the final word of a run.
//   Events that cause no action produce no words.
//   The event is held in the input register, its run is written into a
//   two-run queue once the queue has space, and its first action is then
//   visible on the master channel; a run leaves at one word per cycle while
//   m_tready is high. The input register takes a new event while earlier
//   runs are still leaving, as long as the queue has space.
//   When the receiver stalls, the queue fills and s_tready drops once two
//   runs wait and the input register is occupied; nothing is lost.
//   The cfg channel writes the eight registers (always ready); the user must
//   use it only while the block is idle, which the block does not enforce.
//   Reset (rst, synchronous) loads the default keycodes and timeout, clears
//   all phases, the swapper and the timeout counter, and empties the queue.
// ----------------------------------------------------------------------------
module oneshot_modifier_controller (
  input  logic        clk,
  input  logic        rst,
  // event input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] key_code, [16] pressed, [23:17] zero
  input  logic        s_tuser,   // [0] op
  // action output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] action, [3:1] action_key, [7:4] zero
  output logic        m_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import omc_pkg::*;

  cfg_t       cfg;
  run_t       run;
  logic       run_push;
  logic       run_space;
  logic       out_act;
  logic [2:0] out_key;

  // register file
  omc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // event step logic and state
  omc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_key    (s_tdata[15:0]),
    .in_down   (s_tdata[16]),
    .run_push  (run_push),
    .run_space (run_space),
    .run       (run)
  );

  // run queue and serializer
  omc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .run_push  (run_push),
    .run_space (run_space),
    .run       (run),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_act   (out_act),
    .out_key   (out_key),
    .out_last  (m_tlast)
  );

  assign m_tdata = {4'b0000, out_key, out_act};

endmodule

// ===== bench/oneshot_modifier_controller_tb.sv =====
// ----------------------------------------------------------------------------
// oneshot_modifier_controller_tb
// Self-checking bench for the oneshot modifier controller. Key events and
// ticks go in over the event stream in random bursts. A predictor of the
// modifier phases, swapper and timeout works out each run of actions. The
// monitor compares the action words field by field, in order, under its own
// stall pattern.
// ----------------------------------------------------------------------------
module oneshot_modifier_controller_tb;
  import omc_pkg::*;

  typedef struct packed {
    logic        op;
    logic [15:0] code;
    logic        down;
  } key_event_t;

  typedef struct packed {
    logic       act;
    logic [2:0] key;
    logic       ends_run;
  } action_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;    // [15:0] key_code, [16] pressed, [23:17] zero
  logic        s_tuser = 1'b0;  // [0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [0] action, [3:1] action_key, [7:4] zero
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  oneshot_modifier_controller dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // predictor state, mirrors the block's registers and phases
  logic [15:0] regs [8] = '{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd7, 16'd5000};
  logic [2:0]  mod_phase [NUM_MODS] = '{PH_UP_UNQ, PH_UP_UNQ, PH_UP_UNQ, PH_UP_UNQ};
  logic        swap_on = 1'b0;
  logic        armed = 1'b0;
  logic [15:0] elapsed = '0;

  key_event_t pending_events[$];
  action_t    run_buf[$];
  action_t    expected_actions[$];
  int         pushed_cnt = 0;
  int         accepted_cnt = 0;
  int         mismatch_cnt = 0;

  // ---------------------------------------------------------------- predictor

  function automatic void add_action(logic a, logic [2:0] k);
    if (run_buf.size() < NUM_SLOTS) run_buf.push_back('{act: a, key: k, ends_run: 1'b0});
  endfunction

  function automatic void step_modifier(int m, logic [15:0] k, logic down);
    logic [2:0] ph;
    logic [2:0] mkey;
    logic       cancel;
    logic       oneshot;
    ph      = mod_phase[m];
    mkey    = KEY_SHIFT + 3'(m);
    cancel  = (k == regs[REG_CANCEL_A]) || (k == regs[REG_CANCEL_B]);
    oneshot = cancel || k == regs[REG_SHIFT_TRIG] || k == regs[REG_CTRL_TRIG] ||
              k == regs[REG_ALT_TRIG] || k == regs[REG_CMD_TRIG];
    if (k == regs[int'(REG_SHIFT_TRIG) + m]) begin
      // own trigger
      if (down) begin
        if (ph == PH_UP_UNQ) add_action(ACT_PRESS, mkey);
        mod_phase[m] = PH_DN_UNUSED;
        armed   = 1'b0;
        elapsed = '0;
      end else if (ph == PH_DN_UNUSED) begin
        mod_phase[m] = PH_UP_QUE;
        armed   = 1'b1;
        elapsed = '0;
      end else if (ph == PH_DN_USED) begin
        mod_phase[m] = PH_UP_UNQ;
        add_action(ACT_RELEASE, mkey);
      end
    end else if (down) begin
      if (cancel && ph != PH_UP_UNQ) begin
        mod_phase[m] = PH_UP_UNQ;
        add_action(ACT_RELEASE, mkey);
      end
      // any other key marks the modifier as used
      if (!oneshot) begin
        if (ph == PH_DN_UNUSED) begin
          mod_phase[m] = PH_DN_USED;
        end else if (ph == PH_UP_QUE) begin
          mod_phase[m] = PH_UP_USED;
        end else if (ph == PH_UP_USED) begin
          mod_phase[m] = PH_UP_UNQ;
          add_action(ACT_RELEASE, mkey);
        end
      end
    end else if (!oneshot) begin
      if (ph == PH_DN_UNUSED) begin
        mod_phase[m] = PH_DN_USED;
      end else if (ph == PH_UP_QUE || ph == PH_UP_USED) begin
        mod_phase[m] = PH_UP_UNQ;
        add_action(ACT_RELEASE, mkey);
      end
    end
  endfunction

  function automatic void predict_actions(key_event_t ev);
    run_buf.delete();
    if (ev.op == OP_TICK) begin
      if (elapsed != 16'hFFFF) elapsed++;
      if (armed && elapsed > regs[REG_TIMEOUT]) begin
        for (int m = 0; m < NUM_MODS; m++) begin
          add_action(ACT_RELEASE, KEY_SHIFT + 3'(m));
          mod_phase[m] = PH_UP_UNQ;
        end
        armed   = 1'b0;
        elapsed = '0;
      end
    end else begin
      // swapper first, then the four modifiers in order
      if (ev.code == regs[REG_SWAP_TRIG]) begin
        if (ev.down) begin
          if (!swap_on) begin
            swap_on = 1'b1;
            add_action(ACT_PRESS, KEY_CTRL);
          end
          add_action(ACT_PRESS, KEY_SPACE);
        end else begin
          add_action(ACT_RELEASE, KEY_SPACE);
        end
      end else if (swap_on) begin
        add_action(ACT_RELEASE, KEY_CTRL);
        swap_on = 1'b0;
      end
      for (int m = 0; m < NUM_MODS; m++) step_modifier(m, ev.code, ev.down);
    end
    if (run_buf.size() > 0) run_buf[run_buf.size()-1].ends_run = 1'b1;
    foreach (run_buf[i]) expected_actions.push_back(run_buf[i]);
  endfunction

  // ---------------------------------------------------------------- driver

  int gap_left = 0;
  int burst_left = 0;
  key_event_t sending = '0;

  always @(posedge clk) begin : drive
    logic go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_actions(sending);
        accepted_cnt++;
      end
      if (!s_tvalid || s_tready) begin
        go = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_events.size() > 0) begin
          go = 1'b1;
          sending = pending_events.pop_front();
          s_tdata <= {7'b0, sending.down, sending.code};
          s_tuser <= sending.op;
          // end of a burst opens a gap, sometimes none
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
        s_tvalid <= go;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  int rx_cycle = 0;
  int rx_mode = 0;

  always @(posedge clk) begin : watch
    action_t got;
    action_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{act: m_tdata[0], key: m_tdata[3:1], ends_run: m_tlast};
      if (expected_actions.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected word: action %0d key %0d last %0d", got.act, got.key,
                   got.ends_run);
      end else begin
        want = expected_actions.pop_front();
        if (got.act != want.act || got.key != want.key || got.ends_run != want.ends_run) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("word mismatch: expected action %0d key %0d last %0d, got %0d %0d %0d",
                     want.act, want.key, want.ends_run, got.act, got.key, got.ends_run);
        end
      end
    end
    // receiver stall pattern: free running, random, or one cycle in four
    rx_cycle++;
    if (rx_cycle[5:0] == 6'd0) rx_mode = $urandom_range(0, 2);
    case (rx_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_tready <= (rx_cycle[1:0] == 2'd0);
      end
    endcase
  end

  // ---------------------------------------------------------------- stimulus

  task automatic queue_event(logic op, logic [15:0] code, logic down);
    pending_events.push_back('{op: op, code: code, down: down});
    pushed_cnt++;
  endtask

  // wait until every event is taken and every action word has come out
  task automatic drain();
    while (accepted_cnt != pushed_cnt || expected_actions.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    regs[idx] = val;
  endtask

  task automatic random_config();
    logic [15:0] v;
    for (int i = 0; i < 7; i++) begin
      case ($urandom_range(0, 9))
        0: v = (i > 0) ? regs[$urandom_range(0, i - 1)] : 16'hFFFF;  // shared keycode
        1: v = 16'h0000;
        2: v = 16'hFFFF;
        default: v = 16'($urandom);
      endcase
      write_reg(3'(i), v);
    end
    case ($urandom_range(0, 9))
      0: v = 16'hFFFF;
      1: v = 16'($urandom);
      default: v = 16'($urandom_range(1, 5));
    endcase
    write_reg(REG_TIMEOUT, v);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_random_sequence();
    int          m;
    int          n;
    logic [15:0] other;
    logic [15:0] k;
    m     = $urandom_range(0, NUM_MODS - 1);
    other = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1: begin
        // tap: leaves the modifier queued
        queue_event(OP_KEY, regs[m], 1'b1);
        queue_event(OP_KEY, regs[m], 1'b0);
      end
      2: begin
        // hold and use
        queue_event(OP_KEY, regs[m], 1'b1);
        queue_event(OP_KEY, other, 1'b1);
        queue_event(OP_KEY, other, 1'b0);
        queue_event(OP_KEY, regs[m], 1'b0);
      end
      3: begin
        queue_event(OP_KEY, other, 1'b1);
        queue_event(OP_KEY, other, 1'b0);
      end
      4: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          queue_event(OP_KEY, regs[REG_SWAP_TRIG], 1'b1);
          if ($urandom_range(0, 1)) queue_event(OP_KEY, regs[REG_SWAP_TRIG], 1'b0);
        end
      end
      5: begin
        k = $urandom_range(0, 1) ? regs[REG_CANCEL_A] : regs[REG_CANCEL_B];
        queue_event(OP_KEY, k, 1'b1);
        queue_event(OP_KEY, k, 1'b0);
      end
      6: begin
        // enough ticks to reach a short timeout
        n = (regs[REG_TIMEOUT] < 16'd8) ? $urandom_range(1, int'(regs[REG_TIMEOUT]) + 2)
                                        : $urandom_range(1, 4);
        repeat (n) queue_event(OP_TICK, 16'($urandom), 1'($urandom_range(0, 1)));
      end
      7: begin
        // two modifiers queued, then a plain key
        queue_event(OP_KEY, regs[m], 1'b1);
        queue_event(OP_KEY, regs[m], 1'b0);
        queue_event(OP_KEY, regs[(m + 1) % NUM_MODS], 1'b1);
        queue_event(OP_KEY, regs[(m + 1) % NUM_MODS], 1'b0);
        queue_event(OP_KEY, other, 1'($urandom_range(0, 1)));
      end
      default: begin
        queue_event(1'($urandom_range(0, 1)), other, 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  initial begin : stimulus
    int base;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset settings: hold and use, queue and use, cancel, swapper
    queue_event(OP_KEY, regs[REG_SHIFT_TRIG], 1'b1);
    queue_event(OP_KEY, 16'hFFFF, 1'b1);
    queue_event(OP_KEY, 16'hFFFF, 1'b0);
    queue_event(OP_KEY, regs[REG_SHIFT_TRIG], 1'b0);
    queue_event(OP_KEY, regs[REG_CTRL_TRIG], 1'b1);
    queue_event(OP_KEY, regs[REG_CTRL_TRIG], 1'b0);
    queue_event(OP_KEY, 16'h0000, 1'b1);
    queue_event(OP_KEY, 16'h0000, 1'b0);
    queue_event(OP_KEY, regs[REG_ALT_TRIG], 1'b1);
    queue_event(OP_KEY, regs[REG_ALT_TRIG], 1'b0);
    queue_event(OP_KEY, regs[REG_CANCEL_A], 1'b1);
    queue_event(OP_KEY, regs[REG_SWAP_TRIG], 1'b1);
    queue_event(OP_KEY, regs[REG_SWAP_TRIG], 1'b1);
    queue_event(OP_KEY, regs[REG_SWAP_TRIG], 1'b0);
    queue_event(OP_KEY, regs[REG_CMD_TRIG], 1'b1);
    queue_event(OP_KEY, regs[REG_CANCEL_B], 1'b1);
    drain();

    // zero timeout, and a trigger press disarming while shift is queued
    write_reg(REG_TIMEOUT, 16'd0);
    cfg_valid <= 1'b0;
    queue_event(OP_KEY, regs[REG_SHIFT_TRIG], 1'b1);
    queue_event(OP_KEY, regs[REG_SHIFT_TRIG], 1'b0);
    queue_event(OP_KEY, regs[REG_CTRL_TRIG], 1'b1);
    queue_event(OP_TICK, 16'hFFFF, 1'b1);
    queue_event(OP_KEY, regs[REG_CTRL_TRIG], 1'b0);
    queue_event(OP_TICK, 16'h0000, 1'b0);
    drain();

    // every register on one keycode: six actions from a single event
    for (int i = 0; i < 7; i++) write_reg(3'(i), 16'hFFFF);
    write_reg(REG_TIMEOUT, 16'd1);
    cfg_valid <= 1'b0;
    queue_event(OP_KEY, 16'hFFFF, 1'b1);
    queue_event(OP_KEY, 16'hFFFF, 1'b0);
    queue_event(OP_KEY, 16'hFFFF, 1'b1);
    queue_event(OP_KEY, 16'h1234, 1'b1);
    drain();

    // largest timeout holds a queued modifier, a lower one then fires
    write_reg(REG_SHIFT_TRIG, 16'd1);
    write_reg(REG_CTRL_TRIG, 16'd2);
    write_reg(REG_ALT_TRIG, 16'd3);
    write_reg(REG_CMD_TRIG, 16'd4);
    write_reg(REG_SWAP_TRIG, 16'd5);
    write_reg(REG_CANCEL_A, 16'd6);
    write_reg(REG_CANCEL_B, 16'd7);
    write_reg(REG_TIMEOUT, 16'hFFFF);
    cfg_valid <= 1'b0;
    queue_event(OP_KEY, regs[REG_CMD_TRIG], 1'b1);
    queue_event(OP_KEY, regs[REG_CMD_TRIG], 1'b0);
    repeat (8) queue_event(OP_TICK, 16'h0000, 1'b0);
    drain();
    write_reg(REG_TIMEOUT, 16'd3);
    cfg_valid <= 1'b0;
    queue_event(OP_TICK, 16'h0000, 1'b0);
    drain();

    // random settings, mostly well formed key sequences
    repeat (3) begin
      random_config();
      base = pushed_cnt;
      while (pushed_cnt < base + 40) add_random_sequence();
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("oneshot_modifier_controller_tb OK");
    end else begin
      $display("oneshot_modifier_controller_tb NOT OK");
    end
    $finish;
  end

  // hang guard
  initial begin
    #40000000;
    $display("oneshot_modifier_controller_tb NOT OK");
    $finish;
  end

endmodule
